>>> rtl/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg: shared types and codes of the postfix stack evaluator
// Token and result structs, operation and error codes.
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int unsigned OpW  = 3;
  localparam int unsigned ErrW = 3;
  localparam int unsigned ValW = 32;

  typedef enum logic [OpW-1:0] {
    OP_PUSH   = 3'd0,
    OP_ADD    = 3'd1,
    OP_SUB    = 3'd2,
    OP_MUL    = 3'd3,
    OP_DIV    = 3'd4,
    OP_IGNORE = 3'd5,
    OP_RSV6   = 3'd6,
    OP_RSV7   = 3'd7
  } op_e;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE     = 3'd0,
    ERR_EMPTY    = 3'd1,
    ERR_LEFTOVER = 3'd2,
    ERR_MISSING  = 3'd3,
    ERR_FULL     = 3'd4,
    ERR_DIVZERO  = 3'd5
  } err_e;

  typedef struct packed {
    logic [OpW-1:0]    operation;
    logic signed [31:0] operand_value;
    logic              end_of_expression;
  } token_t;

  typedef struct packed {
    logic signed [31:0] final_value;
    logic [ErrW-1:0]   error_code;
  } result_t;

  // classified token passed from front to back
  typedef struct packed {
    op_e               op;
    logic signed [31:0] value;
    logic              last;
  } cmd_t;

endpackage

>>> rtl/pse_fifo.sv
// ----------------------------------------------------------------------------
// pse_fifo: small register queue of classified tokens
// Decouples the token front end from the execution back end.
// ----------------------------------------------------------------------------
module pse_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  pse_pkg::cmd_t  wdata_i,
  output logic           full_o,
  input  logic           rd_i,
  output pse_pkg::cmd_t  rdata_o,
  output logic           empty_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  pse_pkg::cmd_t     mem_q [Depth];
  logic [AW-1:0]     wp_q, rp_q;
  logic [AW:0]       cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i && !full_o) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr_i && !full_o)
        wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (rd_i && !empty_o)
        rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(wr_i && !full_o) - (AW+1)'(rd_i && !empty_o);
    end
  end
endmodule

>>> rtl/pse_divider.sv
// ----------------------------------------------------------------------------
// pse_divider: bit-serial signed fixed-point divider
// Computes (a << FracBits) / b truncated toward zero, saturated to 32 bits.
// ----------------------------------------------------------------------------
module pse_divider #(
  parameter int unsigned FracBits = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic               done_o,
  output logic signed [31:0] q_o
);
  localparam int unsigned NW = 32 + FracBits;   // dividend magnitude width
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] num_q;
  logic [32:0]   rem_q;
  logic [31:0]   den_q;
  logic          neg_q, busy_q;
  logic [CW-1:0] cnt_q;
  logic [32:0]   rem_sh, rem_sub;
  logic [NW:0]   qmag;

  assign rem_sh  = {rem_q[31:0], num_q[NW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_o <= 1'b0; cnt_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= NW'(a_i[31] ? 33'(-{a_i[31], a_i}) : 33'({1'b0, a_i})) << FracBits;
      den_q <= b_i[31] ? 32'(-b_i) : b_i;
      rem_q <= '0;
      neg_q <= a_i[31] ^ b_i[31];
    end else if (busy_q) begin
      if (!rem_sub[32]) begin
        rem_q <= rem_sub;
        num_q <= {num_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        num_q <= {num_q[NW-2:0], 1'b0};
      end
    end
  end

  // num_q holds the quotient magnitude after the last step
  always_comb begin
    qmag = {1'b0, num_q};
    if (neg_q) begin
      if (qmag > (NW+1)'(33'h080000000)) q_o = 32'sh80000000;
      else q_o = 32'(-qmag);
    end else begin
      if (qmag > (NW+1)'(32'h7fffffff)) q_o = 32'sh7fffffff;
      else q_o = qmag[31:0];
    end
  end
endmodule

>>> rtl/pse_exec.sv
// ----------------------------------------------------------------------------
// pse_exec: back end that runs tokens against the value stack
// Holds the stack, count and sticky error, drives one result register.
// ----------------------------------------------------------------------------
module pse_exec #(
  parameter int unsigned StackDepth = 16,
  parameter int unsigned FracBits   = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pse_pkg::cmd_t    cmd_i,
  input  logic             cmd_valid_i,
  output logic             cmd_take_o,
  output pse_pkg::result_t res_o,
  output logic             res_valid_o,
  input  logic             res_take_i
);
  localparam int unsigned SW = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned CW = $clog2(StackDepth + 1);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_WB} state_e;

  state_e              state_q;
  logic signed [31:0]  stk_q [StackDepth];
  logic [CW-1:0]       cnt_q;
  pse_pkg::err_e       err_q;
  pse_pkg::cmd_t       cur_q;
  logic signed [63:0]  prod_q;
  logic                div_start, div_done;
  logic signed [31:0]  div_q;
  logic signed [31:0]  top_b, top_a;
  logic [SW-1:0]       ia, ib;
  logic signed [63:0]  sh;
  logic signed [31:0]  mul_sat;

  assign ib    = SW'(cnt_q - CW'(1));
  assign ia    = SW'(cnt_q - CW'(2));
  assign top_b = stk_q[ib];
  assign top_a = stk_q[ia];

  assign sh = prod_q >>> FracBits;
  always_comb begin
    if (sh > 64'sh7fffffff) mul_sat = 32'sh7fffffff;
    else if (sh < -64'sh80000000) mul_sat = 32'sh80000000;
    else mul_sat = sh[31:0];
  end

  assign cmd_take_o = (state_q == S_IDLE) && cmd_valid_i && !res_valid_o;
  assign div_start  = cmd_take_o && err_q == pse_pkg::ERR_NONE && cmd_i.op == pse_pkg::OP_DIV
                      && cnt_q >= CW'(2) && top_b != 0;

  pse_divider #(.FracBits(FracBits)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .a_i(top_a), .b_i(top_b),
    .done_o(div_done), .q_o(div_q)
  );

  // finish a token: optionally store result, then close the expression if last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [CW-1:0]      c;
    pse_pkg::err_e      e;
    logic               fin, last;
    logic signed [31:0] nv;
    pse_pkg::result_t   r;
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; err_q <= pse_pkg::ERR_NONE;
      res_valid_o <= 1'b0; res_o <= '0;
    end else begin
      c = cnt_q; e = err_q; fin = 1'b0; last = cur_q.last; nv = stk_q[0];
      r = '0;
      if (res_take_i && res_valid_o) res_valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (cmd_take_o) begin
            cur_q <= cmd_i;
            last  = cmd_i.last;
            fin   = 1'b1;
            if (e == pse_pkg::ERR_NONE) begin
              unique case (cmd_i.op)
                pse_pkg::OP_PUSH: begin
                  if (c == CW'(StackDepth)) e = pse_pkg::ERR_FULL;
                  else begin
                    nv = cmd_i.value;
                    stk_q[SW'(c)] <= nv;
                    c = c + 1'b1;
                  end
                end
                pse_pkg::OP_ADD, pse_pkg::OP_SUB, pse_pkg::OP_MUL, pse_pkg::OP_DIV: begin
                  if (c < CW'(2)) e = pse_pkg::ERR_MISSING;
                  else if (cmd_i.op == pse_pkg::OP_ADD) begin
                    nv = top_a + top_b;
                    stk_q[ia] <= nv; c = c - 1'b1;
                  end else if (cmd_i.op == pse_pkg::OP_SUB) begin
                    nv = top_a - top_b;
                    stk_q[ia] <= nv; c = c - 1'b1;
                  end else if (cmd_i.op == pse_pkg::OP_MUL) begin
                    prod_q  <= 64'(top_a) * 64'(top_b);
                    state_q <= S_MUL; fin = 1'b0;
                  end else if (top_b == 0) e = pse_pkg::ERR_DIVZERO;
                  else begin
                    state_q <= S_DIV; fin = 1'b0;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        S_MUL: begin
          nv = mul_sat;
          stk_q[ia] <= nv; c = c - 1'b1;
          state_q <= S_IDLE; fin = 1'b1;
        end
        S_DIV: begin
          if (div_done) begin
            nv = div_q;
            stk_q[ia] <= nv; c = c - 1'b1;
            state_q <= S_IDLE; fin = 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (fin && last) begin
        if (e != pse_pkg::ERR_NONE) r.error_code = e;
        else if (c == '0) r.error_code = pse_pkg::ERR_EMPTY;
        else if (c > CW'(1)) r.error_code = pse_pkg::ERR_LEFTOVER;
        else r.final_value = nv;
        res_valid_o <= 1'b1;
        res_o <= r;
        c = '0; e = pse_pkg::ERR_NONE;
      end
      cnt_q <= c; err_q <= e;
    end
  end
endmodule

>>> rtl/postfix_stack_evaluator_core.sv
// Execution: push/add/sub/ignore finish in the idle state, multiply passes through
//   S_MUL, divide waits in S_DIV on the bit-serial divider, one quotient bit a cycle.
// Throughput: one token per execution time while no result waits to be popped;
//   a two-entry token queue absorbs input bursts while the back end works.
// Reset: rst_ni clears stack count, sticky error, queue and result register;
//   the stack entries themselves are not cleared.
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_core: reverse Polish evaluator over Q fixed point
// Front end classifies and queues tokens, back end executes them against the stack.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_core #(
  parameter int unsigned STACK_DEPTH   = 16,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  pse_pkg::token_t  token_i,
  output logic             empty,
  input  logic             pop,
  output pse_pkg::result_t result_o
);
  pse_pkg::cmd_t cmd_in, cmd_out;
  logic          q_empty, take, res_valid;

  // classify: map reserved codes onto the ignored-token operation
  always_comb begin
    cmd_in.value = token_i.operand_value;
    cmd_in.last  = token_i.end_of_expression;
    if (token_i.operation > pse_pkg::OP_IGNORE) cmd_in.op = pse_pkg::OP_IGNORE;
    else cmd_in.op = pse_pkg::op_e'(token_i.operation);
  end

  // hold tokens until the back end is free
  pse_fifo #(.Depth(2)) u_fifo (
    .clk_i, .rst_ni, .wr_i(push), .wdata_i(cmd_in), .full_o(full),
    .rd_i(take), .rdata_o(cmd_out), .empty_o(q_empty)
  );

  // execute and drive the result register
  pse_exec #(.StackDepth(STACK_DEPTH), .FracBits(FRACTION_BITS)) u_exec (
    .clk_i, .rst_ni, .cmd_i(cmd_out), .cmd_valid_i(!q_empty), .cmd_take_o(take),
    .res_o(result_o), .res_valid_o(res_valid), .res_take_i(pop)
  );

  assign empty = !res_valid;
endmodule

>>> rtl/pse_checker.sv
// ----------------------------------------------------------------------------
// pse_checker: port-level checks of the evaluator
// Watches the result register side for stability, error codes and reset behavior.
// ----------------------------------------------------------------------------
module pse_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             full,
  input logic             empty,
  input logic             pop,
  input pse_pkg::result_t result_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(result_o)) else $error("result dropped");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && result_o.error_code != pse_pkg::ERR_NONE |-> result_o.final_value == 0)
    else $error("error with value");
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> result_o.error_code <= pse_pkg::ERR_DIVZERO) else $error("bad code");
  a_rst: assert property (@(posedge clk_i) !rst_ni |=> empty && !full)
    else $error("reset state");
endmodule

bind postfix_stack_evaluator_core pse_checker u_chk (
  .clk_i, .rst_ni, .full, .empty, .pop, .result_o
);
